### sv/ccr_pkg.sv
// shared types and constants of the circle collision response unit
package ccr_pkg;

  localparam int RAD_W  = 31;
  localparam int FRIC_W = 17;
  localparam int CFG_DW = 31;

  localparam logic [RAD_W-1:0]  RADIUS_RESET   = 31'd65536;
  localparam logic [FRIC_W-1:0] FRICTION_RESET = 17'd65536;

  // quotient bits kept by the dividers; anything above the cap saturates
  localparam int QW = 41;
  localparam logic [QW-1:0] TERM_CAP = {1'b1, {(QW-1){1'b0}}};

  typedef enum logic [0:0] {
    CFG_RADIUS   = 1'b0,
    CFG_FRICTION = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic signed [31:0] pos_a_x;
    logic signed [31:0] pos_a_y;
    logic signed [31:0] vel_a_x;
    logic signed [31:0] vel_a_y;
    logic signed [31:0] pos_b_x;
    logic signed [31:0] pos_b_y;
    logic signed [31:0] vel_b_x;
    logic signed [31:0] vel_b_y;
    logic [30:0]        centre_distance;
  } req_t;

  typedef struct packed {
    logic signed [31:0] new_pos_a_x;
    logic signed [31:0] new_pos_a_y;
    logic signed [31:0] new_vel_a_x;
    logic signed [31:0] new_vel_a_y;
    logic signed [31:0] new_pos_b_x;
    logic signed [31:0] new_pos_b_y;
    logic signed [31:0] new_vel_b_x;
    logic signed [31:0] new_vel_b_y;
    logic               rest_a;
    logic               rest_b;
  } rsp_t;

endpackage

### sv/ccr_div.sv
// pipelined two-lane restoring divider, one quotient bit per stage, capped result
module ccr_div #(
  parameter int NW = 64,
  parameter int DW = 32,
  parameter int SW = 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [NW-1:0]          num [2],
  input  logic [DW-1:0]          den,
  input  logic [SW-1:0]          side_in,
  output logic                   out_valid,
  output logic [ccr_pkg::QW-1:0] quot [2],
  output logic [SW-1:0]          side_out
);

  localparam int QW = ccr_pkg::QW;
  localparam int HW = NW - QW;
  localparam int CW = (HW > DW) ? HW : DW;

  logic [QW:0]    vld;
  logic [DW-1:0]  den_r  [QW];
  logic [SW-1:0]  side_r [QW+1];
  logic [DW-1:0]  rem    [QW][2];
  logic [QW-1:0]  low    [QW][2];
  logic [QW-1:0]  quo    [QW+1][2];
  logic           capped [QW+1][2];
  logic [DW:0]    trial  [QW][2];
  logic [DW:0]    diff   [QW][2];
  logic           take   [QW][2];

  always_comb begin
    for (int s = 0; s < QW; s++) begin
      for (int l = 0; l < 2; l++) begin
        trial[s][l] = {rem[s][l], low[s][l][QW-1]};
        diff[s][l]  = trial[s][l] - {1'b0, den_r[s]};
        take[s][l]  = trial[s][l] >= {1'b0, den_r[s]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[QW-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // entry stage: quotient already at or above 2^QW means capped
      den_r[0]  <= den;
      side_r[0] <= side_in;
      for (int l = 0; l < 2; l++) begin
        capped[0][l] <= CW'(num[l][NW-1:QW]) >= CW'(den);
        rem[0][l]    <= DW'(num[l][NW-1:QW]);
        low[0][l]    <= num[l][QW-1:0];
        quo[0][l]    <= '0;
      end
      for (int s = 0; s < QW; s++) begin
        side_r[s+1] <= side_r[s];
        for (int l = 0; l < 2; l++) begin
          capped[s+1][l] <= capped[s][l];
          quo[s+1][l]    <= {quo[s][l][QW-2:0], take[s][l]};
        end
      end
      for (int s = 0; s < QW-1; s++) begin
        den_r[s+1] <= den_r[s];
        for (int l = 0; l < 2; l++) begin
          rem[s+1][l] <= take[s][l] ? DW'(diff[s][l]) : DW'(trial[s][l]);
          low[s+1][l] <= {low[s][l][QW-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      quot[l] = (capped[QW][l] || (quo[QW][l][QW-1] && (|quo[QW][l][QW-2:0])))
              ? ccr_pkg::TERM_CAP : quo[QW][l];
    end
  end

  assign out_valid = vld[QW];
  assign side_out  = side_r[QW];

endmodule

### sv/circle_collision_response_unit.sv
// top level of the circle collision response unit
//
//   channel  direction  handshake             carries
//   req      in         req_valid/req_ready   one colliding pair (ccr_pkg::req_t)
//   rsp      out        rsp_valid/rsp_ready   separated pair, new velocities (ccr_pkg::rsp_t)
//   cfg      in         cfg_valid/cfg_ready   cfg_index, cfg_data (radius, friction)
//
// one request enters per cycle unless the output queue is full; its result is offered
// after 17 arithmetic stages, two 42-stage divider pipelines and the output queue
// register, the first stage loading at the edge that takes the request
// reset clears valid bits and loads radius 1.0 and friction 1.0
// a full two-entry output queue freezes every stage at once, so nothing is
// dropped or repeated; req_ready comes from registers only
module circle_collision_response_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  ccr_pkg::req_t                 req,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output ccr_pkg::rsp_t                 rsp,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  ccr_pkg::cfg_idx_t             cfg_index,
  input  logic [ccr_pkg::CFG_DW-1:0]    cfg_data
);

  localparam int QW = ccr_pkg::QW;

  typedef logic signed [31:0] word_t;

  // context words: pos a x/y, vel a x/y, pos b x/y, vel b x/y
  typedef struct packed {
    logic [7:0][31:0] c;
    logic             dzero;
    logic [1:0]       neg;
  } side1_t;

  typedef struct packed {
    logic [7:0][31:0] c;
    logic             rest;
    logic [1:0]       neg;
    logic             lzero;
  } side2_t;

  function automatic word_t sat32(input logic signed [47:0] x);
    word_t r;
    if (x > 48'sh0000_7fff_ffff) begin
      r = 32'sh7fff_ffff;
    end else if (x < -48'sh0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'(x);
    end
    return r;
  endfunction

  // configuration registers
  logic [ccr_pkg::RAD_W-1:0]  radius;
  logic [ccr_pkg::FRIC_W-1:0] friction;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius   <= ccr_pkg::RADIUS_RESET;
      friction <= ccr_pkg::FRICTION_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        ccr_pkg::CFG_RADIUS:   radius   <= cfg_data;
        ccr_pkg::CFG_FRICTION: friction <= cfg_data[ccr_pkg::FRIC_W-1:0];
        default: ;
      endcase
    end
  end

  // output queue and global advance
  ccr_pkg::rsp_t head, spare;
  logic          head_v, spare_v;
  logic          en;

  assign en        = !(head_v && spare_v);
  assign req_ready = en;

  // stage registers
  logic a_v, b_v, c_v, d_v, e_v, f_v, g_v, h_v, i_v, j_v, k_v, l_v, m_v;
  logic n_v, o_v, p_v, q_v;

  word_t               in_c [8];
  word_t               a_c [8];
  logic signed [32:0]  a_d [2];
  logic signed [33:0]  a_ovl;
  logic                a_dzero;
  logic [31:0]         a_den;

  word_t               b_c [8];
  logic [32:0]         b_md [2];
  logic [32:0]         b_movl;
  logic [1:0]          b_neg;
  logic                b_dzero;
  logic [31:0]         b_den;

  logic [63:0]         c_num [2];
  logic [31:0]         c_den;
  side1_t              c_side;

  logic                div1_v;
  logic [QW-1:0]       q1 [2];
  logic [$bits(side1_t)-1:0] side1_out;
  side1_t              s1;
  logic signed [41:0]  disp [2];

  word_t               d_c [8];
  word_t               e_c [8];
  logic signed [32:0]  e_e [2];
  logic signed [32:0]  e_dv [2];
  logic                e_rest;

  word_t               f_c [8];
  logic [32:0]         f_m [2];
  logic [1:0]          f_en;
  logic signed [32:0]  f_dv [2];
  logic                f_rest;
  logic                f_big;

  word_t               g_c [8];
  logic [29:0]         g_em [2];
  logic [1:0]          g_en;
  logic signed [32:0]  g_dv [2];
  logic                g_rest;

  word_t               h_c [8];
  logic signed [30:0]  h_es [2];
  logic [59:0]         h_sq [2];
  logic [29:0]         h_em [2];
  logic [1:0]          h_en;
  logic signed [32:0]  h_dv [2];
  logic                h_rest;

  word_t               i_c [8];
  logic signed [63:0]  i_p [2];
  logic [60:0]         i_len2;
  logic [29:0]         i_em [2];
  logic [1:0]          i_en;
  logic                i_rest;

  word_t               j_c [8];
  logic signed [63:0]  j_dot;
  logic [60:0]         j_len2;
  logic [29:0]         j_em [2];
  logic [1:0]          j_en;
  logic                j_rest;

  word_t               k_c [8];
  logic [62:0]         k_mdot;
  logic [1:0]          k_neg;
  logic                k_lzero;
  logic [60:0]         k_len2;
  logic [29:0]         k_em [2];
  logic                k_rest;

  word_t               l_c [8];
  logic [61:0]         l_pl [2];
  logic [60:0]         l_ph [2];
  logic [1:0]          l_neg;
  logic                l_lzero;
  logic [60:0]         l_len2;
  logic                l_rest;

  logic [92:0]         m_num [2];
  logic [60:0]         m_len2;
  side2_t              m_side;

  logic                div2_v;
  logic [QW-1:0]       q2 [2];
  logic [$bits(side2_t)-1:0] side2_out;
  side2_t              s2;
  logic signed [41:0]  term [2];

  word_t               n_c [8];
  logic signed [41:0]  n_vel [4];
  logic                n_rest;

  word_t               o_c [8];
  logic [40:0]         o_mag [4];
  logic [3:0]          o_neg;
  logic                o_rest;

  word_t               p_c [8];
  logic [41:0]         p_m [4];
  logic [3:0]          p_neg;
  logic                p_rest;
  logic [57:0]         prod [4];

  ccr_pkg::rsp_t       q_rsp;
  word_t               vel_out [4];

  assign in_c[0] = req.pos_a_x;
  assign in_c[1] = req.pos_a_y;
  assign in_c[2] = req.vel_a_x;
  assign in_c[3] = req.vel_a_y;
  assign in_c[4] = req.pos_b_x;
  assign in_c[5] = req.pos_b_y;
  assign in_c[6] = req.vel_b_x;
  assign in_c[7] = req.vel_b_y;

  // valid bits travel with the data, all frozen together when the queue is full
  always_ff @(posedge clk) begin
    if (rst) begin
      {a_v, b_v, c_v, d_v, e_v, f_v, g_v, h_v, i_v} <= '0;
      {j_v, k_v, l_v, m_v, n_v, o_v, p_v, q_v}      <= '0;
    end else if (en) begin
      a_v <= req_valid;
      b_v <= a_v;
      c_v <= b_v;
      d_v <= div1_v;
      e_v <= d_v;
      f_v <= e_v;
      g_v <= f_v;
      h_v <= g_v;
      i_v <= h_v;
      j_v <= i_v;
      k_v <= j_v;
      l_v <= k_v;
      m_v <= l_v;
      n_v <= div2_v;
      o_v <= n_v;
      p_v <= o_v;
      q_v <= p_v;
    end
  end

  // separation: displacement after the first divider
  assign s1 = side1_t'(side1_out);

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      if (s1.dzero) begin
        disp[k] = '0;
      end else if (s1.neg[k]) begin
        disp[k] = -$signed(42'(q1[k]));
      end else begin
        disp[k] = $signed(42'(q1[k]));
      end
    end
  end

  // velocity exchange term after the second divider
  assign s2 = side2_t'(side2_out);

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      if (s2.lzero) begin
        term[k] = '0;
      end else if (s2.neg[k]) begin
        term[k] = -$signed(42'(q2[k]));
      end else begin
        term[k] = $signed(42'(q2[k]));
      end
    end
  end

  assign f_big = (|f_m[0][32:30]) || (|f_m[1][32:30]);

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      prod[j] = o_mag[j] * friction;
      vel_out[j] = sat32(p_neg[j] ? -$signed(48'(p_m[j])) : $signed(48'(p_m[j])));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // a: centre difference and overlap
      a_c     <= in_c;
      for (int k = 0; k < 2; k++) begin
        a_d[k] <= 33'(in_c[k]) - 33'(in_c[4+k]);
      end
      a_ovl   <= $signed({2'b00, radius, 1'b0}) - $signed({3'b000, req.centre_distance});
      a_dzero <= req.centre_distance == '0;
      a_den   <= {req.centre_distance, 1'b0};

      // b: magnitudes and signs
      b_c     <= a_c;
      for (int k = 0; k < 2; k++) begin
        b_md[k]  <= a_d[k][32] ? 33'(-a_d[k]) : 33'(a_d[k]);
        b_neg[k] <= a_d[k][32] ^ a_ovl[33];
      end
      b_movl  <= a_ovl[33] ? 33'(-a_ovl) : 33'(a_ovl);
      b_dzero <= a_dzero;
      b_den   <= a_den;

      // c: dividend of the displacement
      for (int k = 0; k < 2; k++) begin
        c_num[k] <= 64'({33'd0, b_md[k]} * {33'd0, b_movl});
      end
      for (int i = 0; i < 8; i++) begin
        c_side.c[i] <= b_c[i];
      end
      c_side.dzero <= b_dzero;
      c_side.neg   <= b_neg;
      c_den        <= b_den;

      // d: new positions, saturated
      for (int k = 0; k < 2; k++) begin
        d_c[k]   <= sat32(48'($signed(s1.c[k])) + 48'(disp[k]));
        d_c[4+k] <= sat32(48'($signed(s1.c[4+k])) - 48'(disp[k]));
        d_c[2+k] <= $signed(s1.c[2+k]);
        d_c[6+k] <= $signed(s1.c[6+k]);
      end

      // e: separation vector, relative velocity, resting mark
      e_c    <= d_c;
      for (int k = 0; k < 2; k++) begin
        e_e[k]  <= 33'(d_c[k]) - 33'(d_c[4+k]);
        e_dv[k] <= 33'(d_c[2+k]) - 33'(d_c[6+k]);
      end
      e_rest <= d_c[1] >= d_c[5];

      // f: separation magnitudes
      f_c    <= e_c;
      for (int k = 0; k < 2; k++) begin
        f_m[k]  <= e_e[k][32] ? 33'(-e_e[k]) : 33'(e_e[k]);
        f_en[k] <= e_e[k][32];
      end
      f_dv   <= e_dv;
      f_rest <= e_rest;

      // g: scale down a long separation vector
      g_c    <= f_c;
      for (int k = 0; k < 2; k++) begin
        g_em[k] <= f_big ? 30'(f_m[k] >> 3) : 30'(f_m[k]);
      end
      g_en   <= f_en;
      g_dv   <= f_dv;
      g_rest <= f_rest;

      // h: squares and signed separation
      h_c    <= g_c;
      for (int k = 0; k < 2; k++) begin
        h_sq[k] <= {30'd0, g_em[k]} * {30'd0, g_em[k]};
        h_es[k] <= g_en[k] ? -$signed({1'b0, g_em[k]}) : $signed({1'b0, g_em[k]});
      end
      h_em   <= g_em;
      h_en   <= g_en;
      h_dv   <= g_dv;
      h_rest <= g_rest;

      // i: dot product terms and squared length
      i_c    <= h_c;
      for (int k = 0; k < 2; k++) begin
        i_p[k] <= 64'(h_dv[k]) * 64'(h_es[k]);
      end
      i_len2 <= {1'b0, h_sq[0]} + {1'b0, h_sq[1]};
      i_em   <= h_em;
      i_en   <= h_en;
      i_rest <= h_rest;

      // j: dot product
      j_c    <= i_c;
      j_dot  <= i_p[0] + i_p[1];
      j_len2 <= i_len2;
      j_em   <= i_em;
      j_en   <= i_en;
      j_rest <= i_rest;

      // k: dot magnitude and term signs
      k_c     <= j_c;
      k_mdot  <= j_dot[63] ? 63'(-j_dot) : 63'(j_dot);
      for (int k = 0; k < 2; k++) begin
        k_neg[k] <= j_dot[63] ^ j_en[k];
      end
      k_lzero <= j_len2 == '0;
      k_len2  <= j_len2;
      k_em    <= j_em;
      k_rest  <= j_rest;

      // l: dot times separation, split in two partial products
      l_c     <= k_c;
      for (int k = 0; k < 2; k++) begin
        l_pl[k] <= {30'd0, k_mdot[31:0]} * {32'd0, k_em[k]};
        l_ph[k] <= {30'd0, k_mdot[62:32]} * {31'd0, k_em[k]};
      end
      l_neg   <= k_neg;
      l_lzero <= k_lzero;
      l_len2  <= k_len2;
      l_rest  <= k_rest;

      // m: dividend of the exchange term
      for (int k = 0; k < 2; k++) begin
        m_num[k] <= 93'(l_pl[k]) + {l_ph[k], 32'd0};
      end
      for (int i = 0; i < 8; i++) begin
        m_side.c[i] <= l_c[i];
      end
      m_side.rest  <= l_rest;
      m_side.neg   <= l_neg;
      m_side.lzero <= l_lzero;
      m_len2       <= l_len2;

      // n: exchanged velocities
      for (int i = 0; i < 8; i++) begin
        n_c[i] <= $signed(s2.c[i]);
      end
      for (int k = 0; k < 2; k++) begin
        n_vel[k]   <= 42'($signed(s2.c[2+k])) - term[k];
        n_vel[2+k] <= 42'($signed(s2.c[6+k])) + term[k];
      end
      n_rest <= s2.rest;

      // o: velocity magnitudes
      o_c    <= n_c;
      for (int j = 0; j < 4; j++) begin
        o_mag[j] <= n_vel[j][41] ? 41'(-n_vel[j]) : 41'(n_vel[j]);
        o_neg[j] <= n_vel[j][41];
      end
      o_rest <= n_rest;

      // p: friction scaling, truncated toward zero
      p_c    <= o_c;
      for (int j = 0; j < 4; j++) begin
        p_m[j] <= prod[j][57:16];
      end
      p_neg  <= o_neg;
      p_rest <= o_rest;

      // q: saturated result
      q_rsp.new_pos_a_x <= p_c[0];
      q_rsp.new_pos_a_y <= p_c[1];
      q_rsp.new_vel_a_x <= vel_out[0];
      q_rsp.new_vel_a_y <= vel_out[1];
      q_rsp.new_pos_b_x <= p_c[4];
      q_rsp.new_pos_b_y <= p_c[5];
      q_rsp.new_vel_b_x <= vel_out[2];
      q_rsp.new_vel_b_y <= vel_out[3];
      q_rsp.rest_a      <= p_rest;
      q_rsp.rest_b      <= !p_rest;
    end
  end

  // displacement divider: |diff| * |overlap| / (2 * distance)
  ccr_div #(
    .NW (64),
    .DW (32),
    .SW ($bits(side1_t))
  ) u_div_sep (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (c_v),
    .num       (c_num),
    .den       (c_den),
    .side_in   (c_side),
    .out_valid (div1_v),
    .quot      (q1),
    .side_out  (side1_out)
  );

  // exchange divider: |dot| * |e| / |e|^2
  ccr_div #(
    .NW (93),
    .DW (61),
    .SW ($bits(side2_t))
  ) u_div_vel (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (m_v),
    .num       (m_num),
    .den       (m_len2),
    .side_in   (m_side),
    .out_valid (div2_v),
    .quot      (q2),
    .side_out  (side2_out)
  );

  // two-entry output queue: head drives the port, spare catches the stage in flight
  logic push, pop;

  assign push = q_v && en;
  assign pop  = head_v && rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_v  <= 1'b0;
      spare_v <= 1'b0;
    end else begin
      if (pop) begin
        if (spare_v) begin
          head_v  <= 1'b1;
          spare_v <= push;
        end else begin
          head_v  <= push;
        end
      end else if (push) begin
        if (!head_v) begin
          head_v  <= 1'b1;
        end else begin
          spare_v <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (spare_v) begin
        head <= spare;
        if (push) begin
          spare <= q_rsp;
        end
      end else if (push) begin
        head <= q_rsp;
      end
    end else if (push) begin
      if (!head_v) begin
        head <= q_rsp;
      end else begin
        spare <= q_rsp;
      end
    end
  end

  assign rsp_valid = head_v;
  assign rsp       = head;

endmodule
